### sv/qxmm_pkg.sv
// Shared types, widths and constants of the quad-X motor mixer.
package qxmm_pkg;

   localparam int THR_W    = 15;
   localparam int CMD_W    = 16;
   localparam int PULSE_W  = 11;
   localparam int PCT_W    = 7;
   localparam int OUT_W    = 12;
   localparam int FRAC_W   = 4;
   localparam int CEIL_W   = OUT_W + FRAC_W;
   localparam int IDLE_W   = PULSE_W + FRAC_W;
   localparam int SPAN_W   = CEIL_W + 1;
   localparam int PROD_W   = 32;
   localparam int DIV_SH   = 10;
   localparam int QUO_IN_W = 22;
   localparam int RCP_W    = 23;
   localparam int RCP_SH   = 27;
   localparam int QRAW_W   = QUO_IN_W + RCP_W;
   localparam int QUO_W    = QRAW_W - RCP_SH;
   localparam int MIX_W    = 20;
   localparam int ADJ_W    = MIX_W + 1;
   localparam int MOTORS   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = PULSE_W;

   localparam logic [THR_W-1:0]   FULL_THROTTLE_Q8 = THR_W'(25600);
   localparam logic [3:0]         US_PER_PERCENT   = 4'd10;
   localparam logic [RCP_W-1:0]   RECIP_25         = RCP_W'(5368710);
   localparam logic [QUO_IN_W:0]  FLOOR_BIAS       = (QUO_IN_W + 1)'(819200);
   localparam logic [MIX_W-1:0]   QUO_BIAS         = MIX_W'(32768);

   localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = PULSE_W'(1000);
   localparam logic [PULSE_W-1:0] IDLE_PULSE_RST   = PULSE_W'(1050);
   localparam logic [PCT_W-1:0]   MAX_PCT_RST      = PCT_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE    = 2'd0,
      CSR_IDLE_PULSE   = 2'd1,
      CSR_MAX_THROTTLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CEIL_W-1:0]        ceil16;
      logic [IDLE_W-1:0]        idle16;
      logic signed [SPAN_W-1:0] span;
   } cfg_type;

   localparam int CEIL16_RST =
      (int'(MIN_PULSE_RST) + int'(MAX_PCT_RST) * int'(US_PER_PERCENT)) * 16;
   localparam int IDLE16_RST = int'(IDLE_PULSE_RST) * 16;
   localparam cfg_type CFG_RST = {CEIL_W'(CEIL16_RST), IDLE_W'(IDLE16_RST),
                                  SPAN_W'(CEIL16_RST - IDLE16_RST)};

   typedef logic signed [MIX_W-1:0] mix_type;

endpackage

### sv/qxmm_req_if.sv
// Command channel: throttle and roll, pitch, yaw commands.
interface qxmm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [qxmm_pkg::THR_W-1:0]      throttle_q8;
   logic signed [qxmm_pkg::CMD_W-1:0]      roll_cmd;
   logic signed [qxmm_pkg::CMD_W-1:0]      pitch_cmd;
   logic signed [qxmm_pkg::CMD_W-1:0]      yaw_cmd;

   modport source (output valid, throttle_q8, roll_cmd, pitch_cmd, yaw_cmd, input ready);
   modport sink   (input valid, throttle_q8, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

### sv/qxmm_rsp_if.sv
// Result channel: four motor pulse widths.
interface qxmm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [qxmm_pkg::OUT_W-1:0]    front_right_us;
   logic [qxmm_pkg::OUT_W-1:0]    front_left_us;
   logic [qxmm_pkg::OUT_W-1:0]    rear_right_us;
   logic [qxmm_pkg::OUT_W-1:0]    rear_left_us;

   modport source (output valid, front_right_us, front_left_us, rear_right_us, rear_left_us,
                   input ready);
   modport sink   (input valid, front_right_us, front_left_us, rear_right_us, rear_left_us,
                   output ready);
endinterface

### sv/qxmm_csr_if.sv
// Register write channel.
interface qxmm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [qxmm_pkg::CSR_IDX_W-1:0]    index;
   logic [qxmm_pkg::CSR_DAT_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/qxmm_base.sv
// Base pulse pipeline (throttle scaling, floor divide) and quad-X mixing.
module qxmm_base (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  qxmm_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   input  logic        [qxmm_pkg::THR_W-1:0] throttle_q8,
   input  logic signed [qxmm_pkg::CMD_W-1:0] roll_cmd,
   input  logic signed [qxmm_pkg::CMD_W-1:0] pitch_cmd,
   input  logic signed [qxmm_pkg::CMD_W-1:0] yaw_cmd,
   output logic                              mix_valid,
   output qxmm_pkg::mix_type                 mix [qxmm_pkg::MOTORS]
);
   import qxmm_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic signed [CMD_W-1:0]  s1_roll_ff, s1_pitch_ff, s1_yaw_ff;
   logic                     s2_valid_ff, s2_valid_in;
   logic [QRAW_W-1:0]        s2_qraw_ff, s2_qraw_in;
   logic signed [CMD_W-1:0]  s2_roll_ff, s2_pitch_ff, s2_yaw_ff;
   logic                     s3_valid_ff, s3_valid_in;
   mix_type                  s3_mix_ff [MOTORS];
   mix_type                  s3_mix_in [MOTORS];

   logic [THR_W-1:0]         thr_sat;
   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [QUO_IN_W:0] biased;
   logic [QUO_IN_W-1:0]      quo_in;
   logic [QUO_W-1:0]         quo;
   mix_type                  base, roll_x, pitch_x, yaw_x;

   always_comb begin
      thr_sat     = (throttle_q8 > FULL_THROTTLE_Q8) ? FULL_THROTTLE_Q8 : throttle_q8;
      prod_full   = $signed({1'b0, thr_sat}) * cfg.span;
      s1_prod_in  = prod_full[PROD_W-1:0];
      s1_valid_in = in_valid;
   end

   always_comb begin
      prod_sh     = s1_prod_ff >>> DIV_SH;
      biased      = prod_sh[QUO_IN_W:0] + $signed(FLOOR_BIAS);
      quo_in      = biased[QUO_IN_W-1:0];
      s2_qraw_in  = {{RCP_W{1'b0}}, quo_in} * {{QUO_IN_W{1'b0}}, RECIP_25};
      s2_valid_in = s1_valid_ff;
   end

   always_comb begin
      quo     = s2_qraw_ff[QRAW_W-1:RCP_SH];
      base    = $signed({{(MIX_W-IDLE_W){1'b0}}, cfg.idle16})
              + $signed({{(MIX_W-QUO_W){1'b0}}, quo}) - $signed(QUO_BIAS);
      roll_x  = {{(MIX_W-CMD_W){s2_roll_ff[CMD_W-1]}}, s2_roll_ff};
      pitch_x = {{(MIX_W-CMD_W){s2_pitch_ff[CMD_W-1]}}, s2_pitch_ff};
      yaw_x   = {{(MIX_W-CMD_W){s2_yaw_ff[CMD_W-1]}}, s2_yaw_ff};
      s3_mix_in[0] = base - roll_x - pitch_x + yaw_x;
      s3_mix_in[1] = base + roll_x - pitch_x - yaw_x;
      s3_mix_in[2] = base - roll_x + pitch_x - yaw_x;
      s3_mix_in[3] = base + roll_x + pitch_x + yaw_x;
      s3_valid_in  = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= s1_prod_in;
         s1_roll_ff  <= roll_cmd;
         s1_pitch_ff <= pitch_cmd;
         s1_yaw_ff   <= yaw_cmd;
         s2_qraw_ff  <= s2_qraw_in;
         s2_roll_ff  <= s1_roll_ff;
         s2_pitch_ff <= s1_pitch_ff;
         s2_yaw_ff   <= s1_yaw_ff;
         s3_mix_ff   <= s3_mix_in;
      end
   end

   assign mix_valid = s3_valid_ff;
   assign mix       = s3_mix_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage one");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance |=> (s2_valid_ff == $past(s1_valid_ff) && s3_valid_ff == $past(s2_valid_ff)))
      else $error("valid bit lost or repeated in base pipeline");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff)))
      else $error("base pipeline moved during stall");

endmodule

### sv/qxmm_desat.sv
// Desaturation: max/min search, group shift, clamp and output register.
module qxmm_desat (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  qxmm_pkg::cfg_type             cfg,
   input  logic                          mix_valid,
   input  qxmm_pkg::mix_type             mix [qxmm_pkg::MOTORS],
   output logic                          out_valid,
   output logic [qxmm_pkg::OUT_W-1:0]    out_us [qxmm_pkg::MOTORS]
);
   import qxmm_pkg::*;

   logic                    s4_valid_ff, s4_valid_in;
   mix_type                 s4_mix_ff [MOTORS];
   mix_type                 s4_hi_ff, s4_hi_in, s4_lo_ff, s4_lo_in;
   logic                    s5_valid_ff, s5_valid_in;
   mix_type                 s5_mix_ff [MOTORS];
   logic signed [ADJ_W-1:0] s5_delta_ff, s5_delta_in;
   logic                    s6_valid_ff, s6_valid_in;
   logic [OUT_W-1:0]        s6_us_ff [MOTORS];
   logic [OUT_W-1:0]        s6_us_in [MOTORS];

   mix_type                 hi_a, hi_b, lo_a, lo_b, ceil_m, idle_m;
   logic signed [ADJ_W-1:0] excess, deficit, ceil_a, idle_a;
   logic signed [ADJ_W-1:0] adj [MOTORS];
   logic signed [ADJ_W-1:0] clamped [MOTORS];

   assign ceil_m = $signed({{(MIX_W-CEIL_W){1'b0}}, cfg.ceil16});
   assign idle_m = $signed({{(MIX_W-IDLE_W){1'b0}}, cfg.idle16});
   assign ceil_a = $signed({{(ADJ_W-CEIL_W){1'b0}}, cfg.ceil16});
   assign idle_a = $signed({{(ADJ_W-IDLE_W){1'b0}}, cfg.idle16});

   always_comb begin
      hi_a        = (mix[1] > mix[0]) ? mix[1] : mix[0];
      hi_b        = (mix[3] > mix[2]) ? mix[3] : mix[2];
      lo_a        = (mix[1] < mix[0]) ? mix[1] : mix[0];
      lo_b        = (mix[3] < mix[2]) ? mix[3] : mix[2];
      s4_hi_in    = (hi_b > hi_a) ? hi_b : hi_a;
      s4_lo_in    = (lo_b < lo_a) ? lo_b : lo_a;
      s4_valid_in = mix_valid;
   end

   always_comb begin
      excess      = (s4_hi_ff > ceil_m) ? (ADJ_W'(s4_hi_ff) - ceil_a) : '0;
      deficit     = (s4_lo_ff < idle_m) ? (idle_a - ADJ_W'(s4_lo_ff)) : '0;
      s5_delta_in = deficit - excess;
      s5_valid_in = s4_valid_ff;
   end

   always_comb begin
      for (int i = 0; i < MOTORS; i++) begin
         adj[i] = ADJ_W'(s5_mix_ff[i]) + s5_delta_ff;
         if (adj[i] < idle_a) begin
            clamped[i] = idle_a;
         end else if (adj[i] > ceil_a) begin
            clamped[i] = ceil_a;
         end else begin
            clamped[i] = adj[i];
         end
         s6_us_in[i] = clamped[i][CEIL_W-1:FRAC_W];
      end
      s6_valid_in = s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_mix_ff   <= mix;
         s4_hi_ff    <= s4_hi_in;
         s4_lo_ff    <= s4_lo_in;
         s5_mix_ff   <= s4_mix_ff;
         s5_delta_ff <= s5_delta_in;
         s6_us_ff    <= s6_us_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_us    = s6_us_ff;

   a_floor: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && $stable(cfg) && (cfg.ceil16 >= CEIL_W'(cfg.idle16))) |->
         (s6_us_ff[0] >= OUT_W'(cfg.idle16[IDLE_W-1:FRAC_W])
       && s6_us_ff[1] >= OUT_W'(cfg.idle16[IDLE_W-1:FRAC_W])
       && s6_us_ff[2] >= OUT_W'(cfg.idle16[IDLE_W-1:FRAC_W])
       && s6_us_ff[3] >= OUT_W'(cfg.idle16[IDLE_W-1:FRAC_W])))
      else $error("motor pulse below idle");
   a_extent: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && advance) |=> (s5_delta_ff <= $past(idle_a - ADJ_W'(s4_lo_ff))
                                    || $past(s4_lo_ff >= idle_m)))
      else $error("group shift exceeds deficit");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s4_valid_ff) && $stable(s5_valid_ff) && $stable(s6_valid_ff)))
      else $error("desaturation pipeline moved during stall");

endmodule

### sv/quad_x_motor_mixer_top.sv
// A command beat passes three base stages, then three desat stages, on its way to the result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits on rsp_bus.ready.
// The throttle multiply, the reciprocal multiply and the max/min search set the stage cut.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
// Register writes take effect on beats accepted once the write has passed the register file and then cfg_ff.
// Top level: register file, derived limits, and pipeline stall control.
module quad_x_motor_mixer_top (
   input  logic         clock,
   input  logic         reset,
   qxmm_req_if.sink     req_bus,
   qxmm_rsp_if.source   rsp_bus,
   qxmm_csr_if.sink     csr_bus
);
   import qxmm_pkg::*;

   logic [PULSE_W-1:0] min_pulse_ff, min_pulse_in;
   logic [PULSE_W-1:0] idle_pulse_ff, idle_pulse_in;
   logic [PCT_W-1:0]   max_pct_ff, max_pct_in;
   cfg_type            cfg_ff, cfg_in;
   logic [OUT_W-1:0]   ceil_us;
   logic               advance;
   logic               mix_valid;
   mix_type            mix [MOTORS];
   logic               out_valid;
   logic [OUT_W-1:0]   out_us [MOTORS];

   assign csr_bus.ready = 1'b1;

   always_comb begin
      min_pulse_in  = min_pulse_ff;
      idle_pulse_in = idle_pulse_ff;
      max_pct_in    = max_pct_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MIN_PULSE:    min_pulse_in  = csr_bus.data;
            CSR_IDLE_PULSE:   idle_pulse_in = csr_bus.data;
            CSR_MAX_THROTTLE: max_pct_in    = csr_bus.data[PCT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      ceil_us       = OUT_W'(min_pulse_ff) + OUT_W'(max_pct_ff * US_PER_PERCENT);
      cfg_in.ceil16 = {ceil_us, {FRAC_W{1'b0}}};
      cfg_in.idle16 = {idle_pulse_ff, {FRAC_W{1'b0}}};
      cfg_in.span   = $signed({1'b0, cfg_in.ceil16}) - $signed({2'b0, cfg_in.idle16});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff  <= MIN_PULSE_RST;
         idle_pulse_ff <= IDLE_PULSE_RST;
         max_pct_ff    <= MAX_PCT_RST;
      end else begin
         min_pulse_ff  <= min_pulse_in;
         idle_pulse_ff <= idle_pulse_in;
         max_pct_ff    <= max_pct_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance       = !out_valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   qxmm_base u_base (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg_ff),
      .in_valid    (req_bus.valid),
      .throttle_q8 (req_bus.throttle_q8),
      .roll_cmd    (req_bus.roll_cmd),
      .pitch_cmd   (req_bus.pitch_cmd),
      .yaw_cmd     (req_bus.yaw_cmd),
      .mix_valid   (mix_valid),
      .mix         (mix)
   );

   qxmm_desat u_desat (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .mix_valid (mix_valid),
      .mix       (mix),
      .out_valid (out_valid),
      .out_us    (out_us)
   );

   assign rsp_bus.valid          = out_valid;
   assign rsp_bus.front_right_us = out_us[0];
   assign rsp_bus.front_left_us  = out_us[1];
   assign rsp_bus.rear_right_us  = out_us[2];
   assign rsp_bus.rear_left_us   = out_us[3];

endmodule

### tb/testbench.sv
// Self-checking testbench for the quad-X motor mixer: directed corners, then random commands.
`timescale 1ns / 100ps

module testbench;
   import qxmm_pkg::*;

   localparam int     SETTLE_CYCLES = 10;
   localparam int     STALL_LIMIT   = 5000;
   localparam longint PCT_STEP_US   = 10;
   localparam longint FULL_Q8       = 25600;
   localparam int     SEGMENTS      = 4;
   localparam int     SEGMENT_BEATS = 70;

   typedef struct packed {
      logic [OUT_W-1:0] front_right;
      logic [OUT_W-1:0] front_left;
      logic [OUT_W-1:0] rear_right;
      logic [OUT_W-1:0] rear_left;
   } motor_pulses_type;

   logic clock;
   logic reset;

   qxmm_req_if req_bus ();
   qxmm_rsp_if rsp_bus ();
   qxmm_csr_if csr_bus ();

   quad_x_motor_mixer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   int pulse_min_us;
   int pulse_idle_us;
   int throttle_limit_pct;

   motor_pulses_type pulses_expected[$];
   int mismatch_count   = 0;
   int beats_sent       = 0;
   int settings_applied = 0;
   int src_idle_pct     = 35;
   int sink_idle_pct    = 70;
   int idle_cycles      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic motor_pulses_type mix_motors(input logic [THR_W-1:0] thr,
                                                   input logic signed [CMD_W-1:0] roll_in,
                                                   input logic signed [CMD_W-1:0] pitch_in,
                                                   input logic signed [CMD_W-1:0] yaw_in);
      longint t, roll, pitch, yaw;
      longint ceil16, idle16, prod, quo, base, hi, lo;
      longint m [MOTORS];
      motor_pulses_type res;
      t = thr;
      roll = roll_in;
      pitch = pitch_in;
      yaw = yaw_in;
      if (t > FULL_Q8) t = FULL_Q8;
      ceil16 = (longint'(pulse_min_us) + PCT_STEP_US * longint'(throttle_limit_pct)) * 16;
      idle16 = longint'(pulse_idle_us) * 16;
      prod = t * (ceil16 - idle16);
      quo = prod / FULL_Q8;
      if ((prod % FULL_Q8) != 0 && prod < 0) quo = quo - 1;
      base = idle16 + quo;
      m[0] = base - roll - pitch + yaw;
      m[1] = base + roll - pitch - yaw;
      m[2] = base - roll + pitch - yaw;
      m[3] = base + roll + pitch + yaw;
      hi = m[0];
      lo = m[0];
      for (int i = 1; i < MOTORS; i++) begin
         if (m[i] > hi) hi = m[i];
         if (m[i] < lo) lo = m[i];
      end
      if (hi > ceil16) begin
         for (int i = 0; i < MOTORS; i++) m[i] = m[i] - (hi - ceil16);
      end
      if (lo < idle16) begin
         for (int i = 0; i < MOTORS; i++) m[i] = m[i] + (idle16 - lo);
      end
      for (int i = 0; i < MOTORS; i++) begin
         if (m[i] < idle16) m[i] = idle16;
         else if (m[i] > ceil16) m[i] = ceil16;
      end
      res.front_right = OUT_W'(m[0] >> FRAC_W);
      res.front_left  = OUT_W'(m[1] >> FRAC_W);
      res.rear_right  = OUT_W'(m[2] >> FRAC_W);
      res.rear_left   = OUT_W'(m[3] >> FRAC_W);
      return res;
   endfunction

   task automatic send_command(input logic [THR_W-1:0] thr,
                               input logic signed [CMD_W-1:0] roll,
                               input logic signed [CMD_W-1:0] pitch,
                               input logic signed [CMD_W-1:0] yaw);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.throttle_q8 = thr;
      req_bus.roll_cmd    = roll;
      req_bus.pitch_cmd   = pitch;
      req_bus.yaw_cmd     = yaw;
      do @(posedge clock); while (!req_bus.ready);
      pulses_expected.push_back(mix_motors(thr, roll, pitch, yaw));
      beats_sent++;
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_MIN_PULSE:    pulse_min_us       = value & 'h7FF;
         CSR_IDLE_PULSE:   pulse_idle_us      = value & 'h7FF;
         CSR_MAX_THROTTLE: throttle_limit_pct = value & 'h7F;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // drop valid, drain the pipeline and let it go quiet
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pulses_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input int min_us, input int idle_us, input int limit_pct);
      drain_pipeline();
      write_register(CSR_MIN_PULSE, min_us);
      write_register(CSR_IDLE_PULSE, idle_us);
      write_register(CSR_MAX_THROTTLE, limit_pct);
      settings_applied++;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [CMD_W-1:0] pick_command(input int kind);
      int v;
      if (kind < 70) v = int'($urandom_range(0, 6400)) - 3200;
      else if (kind < 85) v = int'($urandom_range(0, 64000)) - 32000;
      else v = int'($urandom);
      return CMD_W'(v);
   endfunction

   task automatic send_random_command();
      int kind;
      logic [THR_W-1:0] thr;
      kind = $urandom_range(99);
      if (kind < 85) thr = THR_W'($urandom_range(0, 25600));
      else thr = THR_W'($urandom);
      send_command(thr, pick_command(kind), pick_command(kind), pick_command(kind));
   endtask

   function automatic int pick_pulse();
      case ($urandom_range(0, 5))
         0: return 500;
         1: return 1500;
         2: return 0;
         3: return 2047;
         default: return $urandom_range(500, 1500);
      endcase
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 100;
         2: return 127;
         default: return $urandom_range(0, 100);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_command(0, 0, 0, 0);
      send_command(25600, 0, 0, 0);
      send_command(32767, 0, 0, 0);
      send_command(25601, 0, 0, 0);
      send_command(12800, 160, -320, 48);
      send_command(25600, 16000, 0, 0);
      send_command(0, 0, 16000, 0);
      send_command(12800, 32000, -32000, 32000);
      send_command(12800, -32768, 32767, -32768);
      send_command(1, -1, -1, 1);
      send_command(7, 5, 3, -9);
      send_command(25600, 32767, 32767, 32767);
   endtask

   task automatic test_ceiling_below_idle();
      apply_setting(500, 1500, 0);
      send_command(0, 0, 0, 0);
      send_command(25600, 0, 0, 0);
      send_command(12800, 800, -800, 400);
   endtask

   task automatic test_limit_over_hundred();
      apply_setting(1500, 500, 127);
      send_command(25600, 0, 0, 0);
      send_command(16384, -4000, 2000, 1000);
      send_command(32767, 32000, 32000, -32000);
      apply_setting(2047, 0, 127);
      send_command(25600, 0, 0, 0);
      send_command(9000, -3000, 1200, -700);
   endtask

   task automatic test_random_traffic(input int src_pct, input int sink_pct);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      for (int s = 0; s < SEGMENTS; s++) begin
         apply_setting(pick_pulse(), pick_pulse(), pick_limit());
         repeat (SEGMENT_BEATS) send_random_command();
      end
   endtask

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= sink_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      motor_pulses_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pulses_expected.size() == 0) begin
            $display("%0t: result beat with none expected: %0d %0d %0d %0d", $time,
                     rsp_bus.front_right_us, rsp_bus.front_left_us,
                     rsp_bus.rear_right_us, rsp_bus.rear_left_us);
            mismatch_count++;
         end else begin
            want = pulses_expected.pop_front();
            check_field("front_right_us", want.front_right, rsp_bus.front_right_us);
            check_field("front_left_us", want.front_left, rsp_bus.front_left_us);
            check_field("rear_right_us", want.rear_right, rsp_bus.rear_right_us);
            check_field("rear_left_us", want.rear_left, rsp_bus.rear_left_us);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.throttle_q8 = '0;
      req_bus.roll_cmd    = '0;
      req_bus.pitch_cmd   = '0;
      req_bus.yaw_cmd     = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_MIN_PULSE;
      csr_bus.data        = '0;
      pulse_min_us        = 1000;
      pulse_idle_us       = 1050;
      throttle_limit_pct  = 100;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_ceiling_below_idle();
      test_limit_over_hundred();
      test_random_traffic(35, 70);
      test_random_traffic(70, 35);
      test_random_traffic(0, 0);
      drain_pipeline();

      $display("Checked %0d command beats across %0d register settings.", beats_sent,
               settings_applied);
      $display("Covered throttle saturation, both shifts, ceiling under idle, limit over 100.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### quad_x_motor_mixer_top.f
sv/qxmm_pkg.sv
sv/qxmm_req_if.sv
sv/qxmm_rsp_if.sv
sv/qxmm_csr_if.sv
sv/qxmm_base.sv
sv/qxmm_desat.sv
sv/quad_x_motor_mixer_top.sv
tb/testbench.sv
